// ===== rtl/vas_pkg.sv =====
// Package for the voice allocator: sizes, codes and request/result structs.
`timescale 1ns / 1ps

package vas_pkg;

    localparam int VOICES       = 16;
    localparam int MONO_OUTPUTS = 8;
    localparam int VW           = $clog2(VOICES);
    localparam int SIDE_LEFT_MONO_COUNT = 4;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_FINISHED = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [2:0] KIND_LEFT  = 3'd0;
    localparam logic [2:0] KIND_RIGHT = 3'd1;
    localparam logic [2:0] KIND_MONO  = 3'd2;

    localparam logic [6:0] LIMIT_RESET = 7'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  channel;
        logic [6:0]  pitch;
        logic [15:0] note_id;
        logic        note_id_valid;
        logic [2:0]  output_kind;
        logic [2:0]  output_number;
        logic        one_shot;
        logic        release_is_zero;
        logic [3:0]  finished_voice;
    } vas_req_t;

    typedef struct packed {
        logic [3:0]  allocated_voice;
        logic        allocated;
        logic        mono_retired;
        logic        limit_stolen;
        logic [3:0]  stolen_voice;
        logic [15:0] released_mask;
        logic [15:0] freed_mask;
        logic [4:0]  active_count;
    } vas_res_t;

    // 0 left, 1 right, 2 none
    function automatic logic [1:0] side_of(input logic [5:0] routing);
        logic [1:0] s;
        s = 2'd2;
        if (routing[5:3] == KIND_LEFT)
            s = 2'd0;
        else if (routing[5:3] == KIND_RIGHT)
            s = 2'd1;
        else if (routing[5:3] == KIND_MONO)
            s = (32'(routing[2:0]) < SIDE_LEFT_MONO_COUNT) ? 2'd0 : 2'd1;
        return s;
    endfunction

endpackage

// ===== rtl/voice_allocator_with_side_limits.sv =====
// Voice allocator top level: request FSM scanning a voice table held in RAM.
// Throughput: one request at a time; the table RAM's single read port is
// scanned one entry per cycle, a second time for a note on only when no mono voice
// is reused and every voice is still active. A stalled result holds off the next
// request. Reset clears flags, sets next age to 1 and limit to 4; RAM needs no clearing.
`timescale 1ns / 1ps

module voice_allocator_with_side_limits
    import vas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  vas_req_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output vas_res_t    out_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN1 = 6'b000010,
        S_DEC1  = 6'b000100,
        S_SCAN2 = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // entry: channel, pitch, note id, routing, flags, age
    typedef struct packed {
        logic [3:0]  channel;
        logic [6:0]  pitch;
        logic [15:0] note_id;
        logic [5:0]  routing;
        logic [1:0]  flags;
        logic [31:0] age;
    } entry_t;

    entry_t mem [VOICES];
    entry_t rd_q;
    logic [VW-1:0] raddr;
    logic          we;
    logic [VW-1:0] waddr;
    entry_t        wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_q <= mem[raddr];
    end

    state_t state_reg, state_next;
    logic [VOICES-1:0] act_reg, act_next, rel_reg, rel_next;
    logic [31:0] age_reg, age_next;
    logic [6:0]  limit_reg;
    vas_req_t    req_reg, req_next;
    vas_res_t    res_reg, res_next;
    logic        ov_reg, ov_next;
    logic [VW:0] idx_reg, idx_next;   // address issued
    logic        rv_reg, rv_next;     // read data valid this cycle
    logic [VW-1:0] ri_reg, ri_next;   // index of rd_q
    logic        done_reg, done_next; // id match stop (note off)
    logic        mono_hit_reg, mono_hit_next;
    logic [VW-1:0] mono_slot_reg, mono_slot_next;
    logic [VW:0] cnt_reg, cnt_next;
    logic        old_v_reg, old_v_next;
    logic [VW-1:0] old_i_reg, old_i_next;
    logic [31:0] old_a_reg, old_a_next;
    logic [VW-1:0] slot_reg, slot_next;

    logic accept_in;
    logic [5:0] req_routing;
    logic req_mono;
    logic [1:0] req_side;
    logic [6:0] lim;
    logic cur_act;
    logic match;

    assign pready = 1'b1;
    assign prdata = {25'd0, limit_reg};
    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign accept_in = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_data = res_reg;

    assign req_routing = {req_reg.output_kind, req_reg.output_number};
    assign req_mono = (req_reg.output_kind == KIND_MONO)
        && (32'(req_reg.output_number) < MONO_OUTPUTS);
    assign req_side = side_of(req_routing);
    assign lim = (limit_reg == 7'd0) ? 7'd1 : limit_reg;
    assign cur_act = act_reg[ri_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && paddr == 1'b0)
            limit_reg <= pwdata[6:0];
    end

    always_comb
    begin
        state_next = state_reg;
        act_next = act_reg;
        rel_next = rel_reg;
        age_next = age_reg;
        req_next = req_reg;
        res_next = res_reg;
        ov_next = ov_reg && out_stall;
        idx_next = idx_reg;
        rv_next = 1'b0;
        ri_next = ri_reg;
        done_next = done_reg;
        mono_hit_next = mono_hit_reg;
        mono_slot_next = mono_slot_reg;
        cnt_next = cnt_reg;
        old_v_next = old_v_reg;
        old_i_next = old_i_reg;
        old_a_next = old_a_reg;
        slot_next = slot_reg;
        raddr = idx_reg[VW-1:0];
        we = 1'b0;
        waddr = slot_reg;
        wdata = '{channel: req_reg.channel, pitch: req_reg.pitch,
                  note_id: req_reg.note_id, routing: req_routing,
                  flags: {req_reg.release_is_zero, req_reg.one_shot},
                  age: age_reg};
        match = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    req_next = in_data;
                    res_next = '0;
                    idx_next = '0;
                    done_next = 1'b0;
                    mono_hit_next = 1'b0;
                    cnt_next = '0;
                    old_v_next = 1'b0;
                    case (in_data.op)
                        OP_NOTE_ON, OP_NOTE_OFF:
                            state_next = S_SCAN1;
                        OP_FINISHED:
                        begin
                            if (32'(in_data.finished_voice) < VOICES)
                            begin
                                act_next[in_data.finished_voice[VW-1:0]] = 1'b0;
                                rel_next[in_data.finished_voice[VW-1:0]] = 1'b0;
                            end
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            act_next = '0;
                            rel_next = '0;
                            age_next = 32'd1;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // pass 1: mono match, side count and oldest (note on); matching (note off)
            S_SCAN1:
            begin
                if (idx_reg < (VW+1)'(VOICES))
                begin
                    rv_next = 1'b1;
                    ri_next = idx_reg[VW-1:0];
                    idx_next = idx_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    if (req_reg.op == OP_NOTE_ON)
                    begin
                        if (cur_act && req_mono && !mono_hit_reg
                            && rd_q.routing == req_routing)
                        begin
                            mono_hit_next = 1'b1;
                            mono_slot_next = ri_reg;
                        end
                        if (cur_act && req_side != 2'd2
                            && side_of(rd_q.routing) == req_side)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                            if (!old_v_reg || rd_q.age < old_a_reg)
                            begin
                                old_v_next = 1'b1;
                                old_i_next = ri_reg;
                                old_a_next = rd_q.age;
                            end
                        end
                    end
                    else
                    begin
                        match = req_reg.note_id_valid ? (rd_q.note_id == req_reg.note_id)
                                                      : (rd_q.pitch == req_reg.pitch);
                        if (!done_reg && cur_act && rd_q.channel == req_reg.channel
                            && match && !rd_q.flags[0])
                        begin
                            if (rd_q.flags[1])
                            begin
                                act_next[ri_reg] = 1'b0;
                                rel_next[ri_reg] = 1'b0;
                                res_next.freed_mask[ri_reg] = 1'b1;
                            end
                            else
                            begin
                                rel_next[ri_reg] = 1'b1;
                                res_next.released_mask[ri_reg] = 1'b1;
                            end
                            if (req_reg.note_id_valid)
                                done_next = 1'b1;
                        end
                    end
                    if (32'(ri_reg) == VOICES-1)
                        state_next = (req_reg.op == OP_NOTE_ON) ? S_DEC1 : S_DONE;
                end
            end

            S_DEC1:
            begin
                idx_next = '0;
                old_v_next = 1'b0;
                if (mono_hit_reg)
                begin
                    res_next.mono_retired = 1'b1;
                    slot_next = mono_slot_reg;
                    state_next = S_WRITE;
                end
                else
                begin
                    if (req_side != 2'd2 && old_v_reg && {2'b00, cnt_reg} >= lim)
                    begin
                        act_next[old_i_reg] = 1'b0;
                        rel_next[old_i_reg] = 1'b0;
                        res_next.limit_stolen = 1'b1;
                        res_next.stolen_voice = old_i_reg;
                    end
                    state_next = S_SCAN2;
                end
            end

            // pass 2: first inactive slot or oldest of all
            S_SCAN2:
            begin
                if (!(|(~act_reg)))
                begin
                    if (idx_reg < (VW+1)'(VOICES))
                    begin
                        rv_next = 1'b1;
                        ri_next = idx_reg[VW-1:0];
                        idx_next = idx_reg + 1'b1;
                    end
                    if (rv_reg)
                    begin
                        if (!old_v_reg || rd_q.age < old_a_reg)
                        begin
                            old_v_next = 1'b1;
                            old_i_next = ri_reg;
                            old_a_next = rd_q.age;
                            slot_next = ri_reg;
                        end
                        if (32'(ri_reg) == VOICES-1)
                            state_next = S_WRITE;
                    end
                end
                else
                begin
                    for (int i = VOICES-1; i >= 0; i--)
                        if (!act_reg[i])
                            slot_next = VW'(i);
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                we = 1'b1;
                act_next[slot_reg] = 1'b1;
                rel_next[slot_reg] = 1'b0;
                age_next = age_reg + 32'd1;
                res_next.allocated = 1'b1;
                res_next.allocated_voice = slot_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!(ov_reg && out_stall))
                begin
                    res_next.active_count = 5'($countones(act_reg));
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg <= '0;
            rel_reg <= '0;
            age_reg <= 32'd1;
            ov_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg <= act_next;
            rel_reg <= rel_next;
            age_reg <= age_next;
            ov_reg <= ov_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        idx_reg <= idx_next;
        ri_reg <= ri_next;
        done_reg <= done_next;
        mono_hit_reg <= mono_hit_next;
        mono_slot_reg <= mono_slot_next;
        cnt_reg <= cnt_next;
        old_v_reg <= old_v_next;
        old_i_reg <= old_i_next;
        old_a_reg <= old_a_next;
        slot_reg <= slot_next;
    end

endmodule
